// ----- hw/rtl/button_click_classifier_defines.svh -----
// Assertion macros for the button click classifier checker
`ifndef BUTTON_CLICK_CLASSIFIER_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bcc_pkg.sv -----
// Shared codes and reset values for the button click classifier
`timescale 1ns / 1ps

package bcc_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int HOLD_W = 16;
    localparam int OP_W   = 2;
    localparam int IDX_W  = 2;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_EDGE        = 2'd0;
    localparam logic [OP_W-1:0] OP_READ_SINGLE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_DOUBLE = 2'd2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_PRESS_MIN     = 2'd0;
    localparam logic [IDX_W-1:0] REG_PRESS_MAX     = 2'd1;
    localparam logic [IDX_W-1:0] REG_DOUBLE_WINDOW = 2'd2;

    // Register reset values, milliseconds
    localparam logic [CFG_W-1:0] PRESS_MIN_RST     = 16'd20;
    localparam logic [CFG_W-1:0] PRESS_MAX_RST     = 16'd1200;
    localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RST = 16'd400;

    // Pin levels (active-low button)
    localparam logic LEVEL_PRESSED = 1'b0;

endpackage

// ----- hw/rtl/button_click_classifier.sv -----
// Single/double click classifier for one active-low push button
//
//  Channel  Signals                               Direction  Flow
//  -------  ------------------------------------  ---------  ----------------
//  in       in_valid in_stall op pin_level time_ms  sink       valid / stall
//  out      out_valid out_stall single_fired       source     valid / stall
//           double_fired hold_ms
//  cfg      cfg_we cfg_index cfg_data              sink       write only
//
// A request passes through the input register, then the result register.
// One request is accepted per cycle while in_stall is low; the click state updates in a single pass.
// Reset (rst_n low, asynchronous) clears the click state and both stage valids and loads the
// register defaults. A stall on the output holds the result register and,
// once the input register is also full, stalls the input.
`timescale 1ns / 1ps

module button_click_classifier
    import bcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   op,
    input  logic              pin_level,
    input  logic [TIME_W-1:0] time_ms,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              single_fired,
    output logic              double_fired,
    output logic [HOLD_W-1:0] hold_ms,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic [CFG_W-1:0]  press_min_reg;
    logic [CFG_W-1:0]  press_max_reg;
    logic [CFG_W-1:0]  window_reg;

    logic [TIME_W-1:0] press_start_reg, press_start_next;
    logic [TIME_W-1:0] last_release_reg, last_release_next;
    logic              release_valid_reg, release_valid_next;
    logic [HOLD_W-1:0] last_hold_reg, last_hold_next;
    logic              single_pending_reg, single_pending_next;
    logic              double_pending_reg, double_pending_next;

    logic              s1_valid_reg, s1_valid_next;
    logic [OP_W-1:0]   s1_op_reg;
    logic              s1_level_reg;
    logic [TIME_W-1:0] s1_time_reg;

    logic              out_valid_reg, out_valid_next;
    logic              single_fired_reg, single_fired_next;
    logic              double_fired_reg, double_fired_next;
    logic [HOLD_W-1:0] hold_ms_reg, hold_ms_next;

    logic              out_ready;
    logic              s1_adv;
    logic              in_take;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] gap;
    logic              hold_ok;
    logic              is_double;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;

    assign s1_valid_next  = in_stall ? s1_valid_reg : in_valid;
    assign out_valid_next = out_ready ? s1_valid_reg : out_valid_reg;

    // Wrapping differences against the stored press and release times
    assign held      = s1_time_reg - press_start_reg;
    assign gap       = s1_time_reg - last_release_reg;
    assign hold_ok   = (held >= {{(TIME_W-CFG_W){1'b0}}, press_min_reg})
                    && (held <= {{(TIME_W-CFG_W){1'b0}}, press_max_reg});
    assign is_double = release_valid_reg
                    && (gap < {{(TIME_W-CFG_W){1'b0}}, window_reg});

    always_comb
    begin
        press_start_next    = press_start_reg;
        last_release_next   = last_release_reg;
        release_valid_next  = release_valid_reg;
        last_hold_next      = last_hold_reg;
        single_pending_next = single_pending_reg;
        double_pending_next = double_pending_reg;
        single_fired_next   = 1'b0;
        double_fired_next   = 1'b0;
        hold_ms_next        = '0;

        case (s1_op_reg)
            OP_EDGE:
            begin
                if (s1_level_reg == LEVEL_PRESSED)
                begin
                    press_start_next = s1_time_reg;
                end
                else if (!hold_ok)
                begin
                    // drop the click and forget the remembered release
                    release_valid_next = 1'b0;
                end
                else
                begin
                    last_hold_next = held[HOLD_W-1:0];
                    if (is_double)
                    begin
                        double_pending_next = 1'b1;
                        single_pending_next = 1'b0;
                        release_valid_next  = 1'b0;
                    end
                    else
                    begin
                        single_pending_next = 1'b1;
                        last_release_next   = s1_time_reg;
                        release_valid_next  = 1'b1;
                    end
                end
            end
            OP_READ_SINGLE:
            begin
                if (single_pending_reg)
                begin
                    single_pending_next = 1'b0;
                    single_fired_next   = 1'b1;
                    hold_ms_next        = last_hold_reg;
                end
            end
            OP_READ_DOUBLE:
            begin
                if (double_pending_reg)
                begin
                    double_pending_next = 1'b0;
                    double_fired_next   = 1'b1;
                end
            end
            default:
            begin
                hold_ms_next = '0;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_min_reg <= PRESS_MIN_RST;
            press_max_reg <= PRESS_MAX_RST;
            window_reg    <= DOUBLE_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PRESS_MIN:     press_min_reg <= cfg_data;
                REG_PRESS_MAX:     press_max_reg <= cfg_data;
                REG_DOUBLE_WINDOW: window_reg    <= cfg_data;
                default:           window_reg    <= window_reg;
            endcase
        end
    end

    // Click state and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_start_reg    <= '0;
            last_release_reg   <= '0;
            release_valid_reg  <= 1'b0;
            last_hold_reg      <= '0;
            single_pending_reg <= 1'b0;
            double_pending_reg <= 1'b0;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                press_start_reg    <= press_start_next;
                last_release_reg   <= last_release_next;
                release_valid_reg  <= release_valid_next;
                last_hold_reg      <= last_hold_next;
                single_pending_reg <= single_pending_next;
                double_pending_reg <= double_pending_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg    <= op;
            s1_level_reg <= pin_level;
            s1_time_reg  <= time_ms;
        end
        if (s1_adv)
        begin
            single_fired_reg <= single_fired_next;
            double_fired_reg <= double_fired_next;
            hold_ms_reg      <= hold_ms_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign single_fired = single_fired_reg;
    assign double_fired = double_fired_reg;
    assign hold_ms      = hold_ms_reg;

endmodule

// ----- hw/rtl/bcc_checker.sv -----
// Port-level checks for the button click classifier, bound to the top level
`timescale 1ns / 1ps
`include "button_click_classifier_defines.svh"

module bcc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        single_fired,
    input logic        double_fired,
    input logic [15:0] hold_ms
);

    logic [17:0] result_bits;

    assign result_bits = {single_fired, double_fired, hold_ms};

    // input backs up only behind a stalled, full output
    `BCC_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall,
                    "input stall without output backpressure")

    // one result carries at most one kind of click
    `BCC_ASSERT_NOW(a_one_kind, clk, rst_n, out_valid, !(single_fired && double_fired),
                    "single and double fired together")

    // hold time is reported only with a single click
    `BCC_ASSERT_NOW(a_hold_zero, clk, rst_n, out_valid && !single_fired, hold_ms == 16'd0,
                    "hold time without single click")

    // a stalled result holds
    `BCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                     out_valid && $stable(result_bits), "stalled result changed")

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (.*);

// ----- bench/button_click_classifier_tb.sv -----
// Self-checking bench for the button click classifier: random stall traffic against a predictor
`timescale 1ns / 1ps

module button_click_classifier_tb
    import bcc_pkg::*;
();

    localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;
    localparam logic            LEVEL_RELEASED = ~LEVEL_PRESSED;
    localparam int unsigned     IDLE_MAX       = 18;
    localparam int unsigned     LONG_HOLD      = 300;
    localparam int unsigned     CYCLE_LIMIT    = 600000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              level;
        logic [TIME_W-1:0] stamp;
    } button_req_t;

    typedef struct packed {
        logic              single_hit;
        logic              double_hit;
        logic [HOLD_W-1:0] hold;
    } click_result_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [OP_W-1:0]   op        = OP_EDGE;
    logic              pin_level = LEVEL_RELEASED;
    logic [TIME_W-1:0] time_ms   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              single_fired;
    logic              double_fired;
    logic [HOLD_W-1:0] hold_ms;
    logic              cfg_we    = 1'b0;
    logic [IDX_W-1:0]  cfg_index = REG_PRESS_MIN;
    logic [CFG_W-1:0]  cfg_data  = '0;

    button_click_classifier i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .pin_level    (pin_level),
        .time_ms      (time_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .single_fired (single_fired),
        .double_fired (double_fired),
        .hold_ms      (hold_ms),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Predictor copy of the thresholds and click state
    logic [CFG_W-1:0]  lim_min    = PRESS_MIN_RST;
    logic [CFG_W-1:0]  lim_max    = PRESS_MAX_RST;
    logic [CFG_W-1:0]  dbl_window = DOUBLE_WINDOW_RST;
    logic [TIME_W-1:0] press_at       = '0;
    logic [TIME_W-1:0] release_at     = '0;
    logic              release_armed  = 1'b0;
    logic [HOLD_W-1:0] held_last      = '0;
    logic              single_waiting = 1'b0;
    logic              double_waiting = 1'b0;

    button_req_t   req_backlog[$];
    click_result_t expected_clicks[$];
    button_req_t   cur_req;
    int unsigned   queued_total = 0;
    int unsigned   fail_count   = 0;
    int unsigned   cycle_count  = 0;
    int unsigned   tx_wait      = 0;
    int unsigned   rx_wait      = 0;
    int unsigned   hold_cnt     = 0;
    logic          offer;
    bit            tx_idle_on    = 1'b1;
    bit            rx_idle_on    = 1'b1;
    bit            pressure_go   = 1'b0;
    bit            pressure_done = 1'b0;
    logic [TIME_W-1:0] gen_release = '0;

    function automatic click_result_t classify_request(button_req_t req);
        click_result_t     res;
        logic [TIME_W-1:0] held;
        logic [TIME_W-1:0] gap;
        res = '0;
        case (req.op)
            OP_EDGE:
            begin
                if (req.level == LEVEL_PRESSED)
                begin
                    press_at = req.stamp;
                end
                else
                begin
                    held = req.stamp - press_at;
                    if (held < lim_min || held > lim_max)
                    begin
                        release_armed = 1'b0;
                    end
                    else
                    begin
                        held_last = held[HOLD_W-1:0];
                        gap = req.stamp - release_at;
                        // a second valid release inside the window upgrades to double
                        if (release_armed && gap < dbl_window)
                        begin
                            double_waiting = 1'b1;
                            single_waiting = 1'b0;
                            release_armed  = 1'b0;
                        end
                        else
                        begin
                            single_waiting = 1'b1;
                            release_at     = req.stamp;
                            release_armed  = 1'b1;
                        end
                    end
                end
            end
            OP_READ_SINGLE:
            begin
                if (single_waiting)
                begin
                    single_waiting = 1'b0;
                    res.single_hit = 1'b1;
                    res.hold       = held_last;
                end
            end
            OP_READ_DOUBLE:
            begin
                if (double_waiting)
                begin
                    double_waiting = 1'b0;
                    res.double_hit = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic int unsigned draw_idle(bit enabled);
        return enabled ? $urandom_range(0, IDLE_MAX) : 0;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Request driver: present queued requests, idle between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            op        <= OP_EDGE;
            pin_level <= LEVEL_RELEASED;
            time_ms   <= '0;
            tx_wait = 0;
        end
        else
        begin
            offer = in_valid;
            if (in_valid && !in_stall)
            begin
                expected_clicks.push_back(classify_request(cur_req));
                offer = 1'b0;
                tx_wait = draw_idle(tx_idle_on);
            end
            if (!offer)
            begin
                if (tx_wait != 0)
                begin
                    tx_wait--;
                end
                else if (req_backlog.size() != 0)
                begin
                    cur_req = req_backlog.pop_front();
                    op        <= cur_req.op;
                    pin_level <= cur_req.level;
                    time_ms   <= cur_req.stamp;
                    offer = 1'b1;
                end
            end
            in_valid <= offer;
        end
    end

    // Result monitor: stall at random, hold off once for a long stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait  = 0;
            hold_cnt = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_clicks.size() == 0)
                begin
                    $error("unexpected result: single_fired %0d double_fired %0d hold_ms %0d",
                           single_fired, double_fired, hold_ms);
                    fail_count++;
                end
                else
                begin
                    click_result_t exp_res;
                    exp_res = expected_clicks.pop_front();
                    if (single_fired !== exp_res.single_hit)
                    begin
                        $error("single_fired: expected %0d, got %0d",
                               exp_res.single_hit, single_fired);
                        fail_count++;
                    end
                    if (double_fired !== exp_res.double_hit)
                    begin
                        $error("double_fired: expected %0d, got %0d",
                               exp_res.double_hit, double_fired);
                        fail_count++;
                    end
                    if (hold_ms !== exp_res.hold)
                    begin
                        $error("hold_ms: expected %0d, got %0d", exp_res.hold, hold_ms);
                        fail_count++;
                    end
                end
                rx_wait = draw_idle(rx_idle_on);
            end
            else if (rx_wait != 0)
            begin
                rx_wait--;
            end
            if (pressure_go && !pressure_done)
            begin
                hold_cnt++;
                if (hold_cnt >= LONG_HOLD)
                begin
                    pressure_done = 1'b1;
                end
            end
            out_stall <= (rx_wait != 0) || (pressure_go && !pressure_done);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** button_click_classifier: FAILED **");
        $finish;
    end

    task automatic push_req(logic [OP_W-1:0] code, logic lvl, logic [TIME_W-1:0] stamp);
        button_req_t req;
        req.op    = code;
        req.level = lvl;
        req.stamp = stamp;
        req_backlog.push_back(req);
        queued_total++;
    endtask

    task automatic wait_idle();
        while (req_backlog.size() != 0 || in_valid || expected_clicks.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic program_thresholds(logic [CFG_W-1:0] min_ms, logic [CFG_W-1:0] max_ms,
                                      logic [CFG_W-1:0] win_ms);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PRESS_MIN;
        cfg_data  <= min_ms;
        @(posedge clk);
        cfg_index <= REG_PRESS_MAX;
        cfg_data  <= max_ms;
        @(posedge clk);
        cfg_index <= REG_DOUBLE_WINDOW;
        cfg_data  <= win_ms;
        @(posedge clk);
        cfg_we <= 1'b0;
        lim_min    = min_ms;
        lim_max    = max_ms;
        dbl_window = win_ms;
        @(negedge clk);
    endtask

    function automatic logic [TIME_W-1:0] pick_hold();
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        lo = TIME_W'(lim_min);
        hi = TIME_W'(lim_max);
        case ($urandom_range(0, 7))
            0:       return lo - 1;
            1:       return lo;
            2:       return hi;
            3:       return hi + 1;
            4:       return $urandom;
            default: return (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, 65535);
        endcase
    endfunction

    // Release-to-release gap, aimed at the double-click window edges
    function automatic logic [TIME_W-1:0] pick_gap();
        logic [TIME_W-1:0] win;
        win = TIME_W'(dbl_window);
        case ($urandom_range(0, 5))
            0:       return win - 1;
            1:       return win;
            2:       return win + 1;
            5:       return $urandom;
            default: return $urandom_range(0, 2 * win + 40);
        endcase
    endfunction

    task automatic queue_random(int unsigned n);
        int unsigned       goal;
        logic [TIME_W-1:0] hold;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] rel_t;
        goal = queued_total + n;
        while (queued_total < goal)
        begin
            case ($urandom_range(0, 9))
                7:
                begin
                    push_req(OP_READ_SINGLE, 1'($urandom_range(0, 1)), $urandom);
                    push_req(OP_READ_DOUBLE, 1'($urandom_range(0, 1)), $urandom);
                end
                8:
                begin
                    push_req(OP_W'($urandom_range(OP_EDGE, OP_UNUSED)),
                             1'($urandom_range(0, 1)), $urandom);
                end
                9:
                begin
                    // broken sequence: stray release or a press with no release
                    if ($urandom_range(0, 1) == 0)
                    begin
                        push_req(OP_EDGE, LEVEL_RELEASED, gen_release + $urandom_range(0, 2000));
                    end
                    else
                    begin
                        push_req(OP_EDGE, LEVEL_PRESSED, $urandom);
                    end
                end
                default:
                begin
                    hold = pick_hold();
                    gap  = pick_gap();
                    if (gap < hold)
                    begin
                        gap = hold + $urandom_range(0, 30);
                    end
                    rel_t = gen_release + gap;
                    push_req(OP_EDGE, LEVEL_PRESSED, rel_t - hold);
                    push_req(OP_EDGE, LEVEL_RELEASED, rel_t);
                    gen_release = rel_t;
                    if ($urandom_range(0, 2) == 0)
                    begin
                        push_req(OP_READ_SINGLE, 1'($urandom_range(0, 1)), $urandom);
                    end
                    if ($urandom_range(0, 3) == 0)
                    begin
                        push_req(OP_READ_DOUBLE, 1'($urandom_range(0, 1)), $urandom);
                    end
                end
            endcase
        end
    endtask

    task automatic run_phase(logic [CFG_W-1:0] min_ms, logic [CFG_W-1:0] max_ms,
                             logic [CFG_W-1:0] win_ms, int unsigned n, bit tx_on, bit rx_on);
        wait_idle();
        program_thresholds(min_ms, max_ms, win_ms);
        tx_idle_on = tx_on;
        rx_idle_on = rx_on;
        queue_random(n);
    endtask

    initial
    begin
        logic [CFG_W-1:0] rmin;
        logic [CFG_W-1:0] rmax;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests under the reset thresholds
        push_req(OP_READ_SINGLE, LEVEL_PRESSED, '0);
        push_req(OP_READ_DOUBLE, LEVEL_RELEASED, '1);
        push_req(OP_UNUSED, LEVEL_RELEASED, '1);
        push_req(OP_EDGE, LEVEL_RELEASED, 32'd30);
        push_req(OP_READ_SINGLE, LEVEL_RELEASED, '1);
        push_req(OP_EDGE, LEVEL_PRESSED, 32'd100);
        push_req(OP_EDGE, LEVEL_RELEASED, 32'd200);
        push_req(OP_READ_SINGLE, LEVEL_PRESSED, '0);
        push_req(OP_READ_DOUBLE, LEVEL_PRESSED, '0);
        push_req(OP_EDGE, LEVEL_PRESSED, 32'hFFFF_FFF0);
        push_req(OP_EDGE, LEVEL_RELEASED, 32'h0000_0010);
        push_req(OP_EDGE, LEVEL_PRESSED, 32'h0000_0100);
        push_req(OP_EDGE, LEVEL_RELEASED, 32'h0000_0100 + 19);
        push_req(OP_EDGE, LEVEL_PRESSED, 32'h0000_1000);
        push_req(OP_EDGE, LEVEL_RELEASED, 32'h0000_1000 + 1200);
        push_req(OP_EDGE, LEVEL_PRESSED, 32'h0000_3000);
        push_req(OP_EDGE, LEVEL_RELEASED, 32'h0000_3000 + 1201);
        push_req(OP_EDGE, LEVEL_PRESSED, 32'h0000_4000);
        push_req(OP_EDGE, LEVEL_RELEASED, 32'h0000_4000 + 20);
        push_req(OP_EDGE, LEVEL_PRESSED, 32'h0000_4100);
        push_req(OP_EDGE, LEVEL_RELEASED, 32'h0000_4100 + 20);
        push_req(OP_READ_DOUBLE, LEVEL_RELEASED, 32'h5555_AAAA);
        push_req(OP_READ_SINGLE, LEVEL_RELEASED, 32'hAAAA_5555);
        push_req(OP_EDGE, LEVEL_PRESSED, 32'h0000_5000);
        push_req(OP_EDGE, LEVEL_RELEASED, 32'h0000_5064);
        push_req(OP_EDGE, LEVEL_PRESSED, 32'h0000_5064 + 300);
        push_req(OP_EDGE, LEVEL_RELEASED, 32'h0000_5064 + 400);
        gen_release = $urandom;

        run_phase(PRESS_MIN_RST, PRESS_MAX_RST, DOUBLE_WINDOW_RST, 250, 1'b1, 1'b1);
        run_phase(16'd0, 16'hFFFF, 16'hFFFF, 200, 1'b0, 1'b0);
        run_phase(16'hFFFF, 16'd0, 16'd0, 60, 1'b1, 1'b0);
        run_phase(16'd30, 16'd500, 16'd0, 120, 1'b0, 1'b1);

        // Hold the result side off while requests keep coming back to back
        wait_idle();
        program_thresholds(16'd25, 16'd900, 16'd350);
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b1;
        pressure_go = 1'b1;
        queue_random(200);

        repeat (3)
        begin
            rmin = CFG_W'($urandom_range(0, 120));
            rmax = CFG_W'(rmin + $urandom_range(0, 2500));
            run_phase(rmin, rmax, CFG_W'($urandom_range(0, 1500)), 170,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("** button_click_classifier: PASSED **");
        end
        else
        begin
            $display("** button_click_classifier: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/bcc_pkg.sv
hw/rtl/button_click_classifier.sv
hw/rtl/bcc_checker.sv
bench/button_click_classifier_tb.sv
